@@ design/four_ary_min_heap_queue_unit_assert.svh @@
// ---------------------------------------------------------------------------
// four_ary_min_heap_queue_unit_assert
// assertion macros shared by the heap queue rtl, clocked on i_clk and
// disabled while i_rst_n is low
// ---------------------------------------------------------------------------
`ifndef FOUR_ARY_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH
`define FOUR_ARY_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication
`define FAHQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FAHQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ design/fahq_pkg.sv @@
// ---------------------------------------------------------------------------
// fahq_pkg
// shared constants, node layout and control/status bundles of the heap queue
// ---------------------------------------------------------------------------
package fahq_pkg;

    localparam int CAPACITY = 1024;
    localparam int REF_BITS = 32;
    localparam int COST_W   = 32;
    localparam int WORD_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY + 1);
    localparam int KID_W    = IDX_W + 2;
    localparam int ADDR_W   = $clog2(CAPACITY);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        RD_ROOT,
        RD_PARENT,
        RD_KID,
        RD_CAND,
        RD_TAIL
    } t_rd_sel;

    typedef struct packed {
        logic [COST_W-1:0]   cost;
        logic [REF_BITS-1:0] refw;
        logic                live;
    } t_node;

    // commands from controller to datapath
    typedef struct packed {
        logic    load;
        logic    cnt_inc;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_item;
        logic    wr_up;
        logic    wr_best;
        logic    root_cap;
        logic    tail_cap;
        logic    lim_full;
        logic    lim_tail;
        logic    scan_start;
        logic    scan_step;
        logic    res_load;
        t_status res_status;
        logic    res_data;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic hole_root;
        logic item_lt_rd;
        logic no_kids;
        logic scan_more;
        logic best_lt_tail;
        logic best_has_kids;
        logic root_live;
    } t_dp_sts;

endpackage

@@ design/four_ary_min_heap_queue_unit.sv @@
// ---------------------------------------------------------------------------
// four_ary_min_heap_queue_unit
// 4-ary min-heap priority queue of cost/reference entries
// ---------------------------------------------------------------------------
// Input channel (i_in_valid/o_in_ready): one operation per transfer, insert
// or pop. Output channel (o_out_valid/i_out_ready): one result per operation,
// with status, popped cost and reference, and the occupancy afterwards.
// Operations run one at a time through a node memory with a registered
// read, so each heap level costs memory accesses:
//   insert: the new entry rises from the new last node, moving each larger
//           parent down, until its parent is not larger or it is the root
//   pop:    reads the root, moves the smallest of up to four children up
//           at each level the hole descends, then reads the last entry and
//           lets it rise; each invalid root dropped repeats the pop
// Full insert and empty pop skip the memory. The next operation is taken
// while a result still waits; a stalled receiver holds the finished result
// and the block waits only when the next result is ready to be written.
// Reset (synchronous, active low) empties the heap at once; the node memory
// is not cleared and no node above the occupancy is ever read.
// ---------------------------------------------------------------------------
module four_ary_min_heap_queue_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_opcode,
    input  logic [fahq_pkg::COST_W-1:0] i_key_cost,
    input  logic [fahq_pkg::WORD_W-1:0] i_entry_ref,
    input  logic                        i_entry_live,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_status,
    output logic [fahq_pkg::WORD_W-1:0] o_out_cost,
    output logic [fahq_pkg::WORD_W-1:0] o_out_ref,
    output logic [fahq_pkg::IDX_W-1:0]  o_occupancy
);

    fahq_pkg::t_dp_cmd cmd;
    fahq_pkg::t_dp_sts sts;

    // sequencer
    fahq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // node storage and arithmetic
    fahq_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key_cost   (i_key_cost),
        .i_entry_ref  (i_entry_ref),
        .i_entry_live (i_entry_live),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_status     (o_status),
        .o_out_cost   (o_out_cost),
        .o_out_ref    (o_out_ref),
        .o_occupancy  (o_occupancy)
    );

    `include "four_ary_min_heap_queue_unit_assert.svh"

    // checks
    `FAHQ_ASSERT_NEXT(a_busy_after_transfer, i_in_valid && o_in_ready, !o_in_ready, "accepted while busy")
    `FAHQ_ASSERT_SAME(a_full_occ, o_out_valid && o_status == fahq_pkg::ST_FULL, o_occupancy == fahq_pkg::IDX_W'(fahq_pkg::CAPACITY), "full status below capacity")
    `FAHQ_ASSERT_SAME(a_nodata_zero, o_out_valid && o_status != fahq_pkg::ST_OK, o_out_cost == '0 && o_out_ref == '0, "data on failed operation")
    `FAHQ_ASSERT_SAME(a_empty_occ, o_out_valid && o_status == fahq_pkg::ST_EMPTY, o_occupancy == '0, "empty status with entries")

endmodule

@@ design/fahq_datapath.sv @@
// ---------------------------------------------------------------------------
// fahq_datapath
// node memory, index registers, child scan and result registers
// ---------------------------------------------------------------------------
module fahq_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [fahq_pkg::COST_W-1:0]   i_key_cost,
    input  logic [fahq_pkg::WORD_W-1:0]   i_entry_ref,
    input  logic                          i_entry_live,
    input  fahq_pkg::t_dp_cmd             i_cmd,
    output fahq_pkg::t_dp_sts             o_sts,
    output logic [1:0]                    o_status,
    output logic [fahq_pkg::WORD_W-1:0]   o_out_cost,
    output logic [fahq_pkg::WORD_W-1:0]   o_out_ref,
    output logic [fahq_pkg::IDX_W-1:0]    o_occupancy
);

    localparam int KW = fahq_pkg::KID_W;

    fahq_pkg::t_node r_mem [fahq_pkg::CAPACITY];

    logic [fahq_pkg::IDX_W-1:0] r_count;
    logic [KW-1:0]              r_hole;
    logic [KW-1:0]              r_limit;
    logic [KW-1:0]              r_cand;
    logic [KW-1:0]              r_best_idx;
    logic                       r_best_none;
    fahq_pkg::t_node            r_item;
    fahq_pkg::t_node            r_root;
    fahq_pkg::t_node            r_best;
    fahq_pkg::t_node            r_rd;
    fahq_pkg::t_status          r_res_status;
    logic [fahq_pkg::WORD_W-1:0] r_res_cost;
    logic [fahq_pkg::WORD_W-1:0] r_res_ref;
    logic [fahq_pkg::IDX_W-1:0] r_res_occ;

    logic [KW-1:0]              kid_first;
    logic [KW-1:0]              best_kid_first;
    logic [KW-1:0]              parent;
    logic [KW-1:0]              count_k;
    logic [KW-1:0]              rd_idx;
    logic [fahq_pkg::ADDR_W-1:0] rd_addr;
    logic [fahq_pkg::ADDR_W-1:0] wr_addr;
    logic                       wr_en;
    fahq_pkg::t_node            wr_data;
    logic                       take;

    // index arithmetic
    assign kid_first      = (r_hole << 2) - KW'(2);
    assign best_kid_first = (r_best_idx << 2) - KW'(2);
    assign parent         = (r_hole + KW'(2)) >> 2;
    assign count_k        = KW'(r_count);

    // status toward the controller
    always_comb begin
        o_sts.full          = (r_count == fahq_pkg::IDX_W'(fahq_pkg::CAPACITY));
        o_sts.empty         = (r_count == '0);
        o_sts.hole_root     = (r_hole == KW'(1));
        o_sts.item_lt_rd    = (r_item.cost < r_rd.cost);
        o_sts.no_kids       = (kid_first >= r_limit);
        o_sts.scan_more     = (r_cand < r_limit) && (r_cand < kid_first + KW'(4));
        o_sts.best_lt_tail  = (r_best_idx < count_k);
        o_sts.best_has_kids = (best_kid_first < count_k);
        o_sts.root_live     = r_root.live;
    end

    // read address select
    always_comb begin
        case (i_cmd.rd_sel)
            fahq_pkg::RD_ROOT:   rd_idx = KW'(1);
            fahq_pkg::RD_PARENT: rd_idx = parent;
            fahq_pkg::RD_KID:    rd_idx = kid_first;
            fahq_pkg::RD_CAND:   rd_idx = r_cand;
            fahq_pkg::RD_TAIL:   rd_idx = count_k;
            default:             rd_idx = KW'(1);
        endcase
    end
    assign rd_addr = fahq_pkg::ADDR_W'(rd_idx - KW'(1));

    // write source select, always at the hole
    assign wr_en   = i_cmd.wr_item | i_cmd.wr_up | i_cmd.wr_best;
    assign wr_addr = fahq_pkg::ADDR_W'(r_hole - KW'(1));
    always_comb begin
        if (i_cmd.wr_item) begin
            wr_data = r_item;
        end else if (i_cmd.wr_up) begin
            wr_data = r_rd;
        end else begin
            wr_data = r_best;
        end
    end

    // node memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // later child wins a tie
    assign take = r_best_none || (r_rd.cost <= r_best.cost);

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + fahq_pkg::IDX_W'(1);
        end else if (i_cmd.tail_cap) begin
            r_count <= r_count - fahq_pkg::IDX_W'(1);
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item.cost <= i_key_cost;
            r_item.refw <= fahq_pkg::REF_BITS'(i_entry_ref);
            r_item.live <= i_entry_live;
            r_hole      <= count_k + KW'(1);
        end
        if (i_cmd.root_cap) begin
            r_root <= r_rd;
            r_hole <= KW'(1);
        end
        if (i_cmd.tail_cap) begin
            r_item <= r_rd;
        end
        if (i_cmd.wr_up) begin
            r_hole <= parent;
        end
        if (i_cmd.wr_best) begin
            r_hole <= r_best_idx;
        end
        if (i_cmd.lim_full) begin
            r_limit <= count_k + KW'(1);
        end
        if (i_cmd.lim_tail) begin
            r_limit <= count_k;
        end
        if (i_cmd.scan_start) begin
            r_cand      <= kid_first + KW'(1);
            r_best_none <= 1'b1;
        end
        if (i_cmd.scan_step) begin
            r_best_none <= 1'b0;
            if (take) begin
                r_best     <= r_rd;
                r_best_idx <= r_cand - KW'(1);
            end
        end
        if (i_cmd.rd_en && i_cmd.rd_sel == fahq_pkg::RD_CAND) begin
            r_cand <= r_cand + KW'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            r_res_cost   <= i_cmd.res_data ? r_root.cost : '0;
            r_res_ref    <= i_cmd.res_data ? fahq_pkg::WORD_W'(r_root.refw) : '0;
            r_res_occ    <= r_count;
        end
    end

    assign o_status    = r_res_status;
    assign o_out_cost  = r_res_cost;
    assign o_out_ref   = r_res_ref;
    assign o_occupancy = r_res_occ;

endmodule

@@ design/fahq_ctrl.sv @@
// ---------------------------------------------------------------------------
// fahq_ctrl
// sequencer for insert, pop descent and sift-up, plus channel handshakes
// ---------------------------------------------------------------------------
module fahq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_opcode,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output fahq_pkg::t_dp_cmd o_cmd,
    input  fahq_pkg::t_dp_sts i_sts
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_START,
        S_POP_ROOT,
        S_SCAN_INIT,
        S_SCAN,
        S_SCAN_DONE,
        S_TAIL_RD,
        S_TAIL_CAP,
        S_RISE_RD,
        S_RISE_CMP,
        S_DONE_OP,
        S_FIN
    } t_state;

    t_state            r_state, n_state;
    logic              r_is_pop, n_is_pop;
    logic              r_first, n_first;
    logic              r_out_valid, n_out_valid;
    fahq_pkg::t_status r_res_status, n_res_status;
    logic              r_res_data, n_res_data;

    // next state and datapath commands
    always_comb begin
        n_state      = r_state;
        n_is_pop     = r_is_pop;
        n_first      = r_first;
        n_out_valid  = r_out_valid;
        n_res_status = r_res_status;
        n_res_data   = r_res_data;
        o_cmd        = '0;
        o_cmd.rd_sel = fahq_pkg::RD_ROOT;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_is_pop   = (i_opcode == fahq_pkg::OP_POP);
                    n_res_data = 1'b0;
                    if (i_opcode == fahq_pkg::OP_POP) begin
                        if (i_sts.empty) begin
                            n_res_status = fahq_pkg::ST_EMPTY;
                            n_state      = S_FIN;
                        end else begin
                            n_state = S_POP_START;
                        end
                    end else if (i_sts.full) begin
                        n_res_status = fahq_pkg::ST_FULL;
                        n_state      = S_FIN;
                    end else begin
                        o_cmd.cnt_inc = 1'b1;
                        n_state       = S_RISE_RD;
                    end
                end
            end
            S_POP_START: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = fahq_pkg::RD_ROOT;
                n_state      = S_POP_ROOT;
            end
            S_POP_ROOT: begin
                o_cmd.root_cap = 1'b1;
                o_cmd.lim_full = 1'b1;
                n_first        = 1'b1;
                n_state        = S_SCAN_INIT;
            end
            S_SCAN_INIT: begin
                if (i_sts.no_kids) begin
                    n_state = S_TAIL_RD;
                end else begin
                    o_cmd.rd_en      = 1'b1;
                    o_cmd.rd_sel     = fahq_pkg::RD_KID;
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_more) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = fahq_pkg::RD_CAND;
                end else begin
                    n_state = S_SCAN_DONE;
                end
            end
            S_SCAN_DONE: begin
                // first look includes the last entry and only decides whether to descend
                if (r_first) begin
                    if (i_sts.best_lt_tail) begin
                        o_cmd.lim_tail = 1'b1;
                        n_first        = 1'b0;
                        n_state        = S_SCAN_INIT;
                    end else begin
                        n_state = S_TAIL_RD;
                    end
                end else begin
                    o_cmd.wr_best = 1'b1;
                    n_state       = i_sts.best_has_kids ? S_SCAN_INIT : S_TAIL_RD;
                end
            end
            S_TAIL_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = fahq_pkg::RD_TAIL;
                n_state      = S_TAIL_CAP;
            end
            S_TAIL_CAP: begin
                o_cmd.tail_cap = 1'b1;
                n_state        = S_RISE_RD;
            end
            S_RISE_RD: begin
                if (i_sts.hole_root) begin
                    o_cmd.wr_item = 1'b1;
                    n_state       = S_DONE_OP;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = fahq_pkg::RD_PARENT;
                    n_state      = S_RISE_CMP;
                end
            end
            S_RISE_CMP: begin
                if (i_sts.item_lt_rd) begin
                    o_cmd.wr_up = 1'b1;
                    n_state     = S_RISE_RD;
                end else begin
                    o_cmd.wr_item = 1'b1;
                    n_state       = S_DONE_OP;
                end
            end
            S_DONE_OP: begin
                // invalid roots are dropped and the pop repeats
                if (!r_is_pop) begin
                    n_res_status = fahq_pkg::ST_OK;
                    n_res_data   = 1'b0;
                    n_state      = S_FIN;
                end else if (i_sts.root_live) begin
                    n_res_status = fahq_pkg::ST_OK;
                    n_res_data   = 1'b1;
                    n_state      = S_FIN;
                end else if (i_sts.empty) begin
                    n_res_status = fahq_pkg::ST_EMPTY;
                    n_res_data   = 1'b0;
                    n_state      = S_FIN;
                end else begin
                    n_state = S_POP_START;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.res_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        o_cmd.res_status = r_res_status;
        o_cmd.res_data   = r_res_data;
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_is_pop     <= 1'b0;
            r_first      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_res_status <= fahq_pkg::ST_OK;
            r_res_data   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_is_pop     <= n_is_pop;
            r_first      <= n_first;
            r_out_valid  <= n_out_valid;
            r_res_status <= n_res_status;
            r_res_data   <= n_res_data;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ bench/four_ary_min_heap_queue_unit_tb.sv @@
// ---------------------------------------------------------------------------
// four_ary_min_heap_queue_unit_tb
// drives random insert/pop traffic with gaps and a long output stall, keeps
// a shadow 4-ary heap to predict each result, and checks results in order
// ---------------------------------------------------------------------------
module four_ary_min_heap_queue_unit_tb;

    typedef struct {
        logic        op;
        logic [31:0] cost;
        logic [31:0] refw;
        logic        live;
    } t_op_item;

    typedef struct {
        fahq_pkg::t_status status;
        logic [31:0]       cost;
        logic [31:0]       refw;
        logic [10:0]       occ;
    } t_result;

    localparam longint CYCLE_LIMIT = 3000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_opcode = fahq_pkg::OP_INSERT;
    logic [31:0] i_key_cost = '0;
    logic [31:0] i_entry_ref = '0;
    logic        i_entry_live = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_out_cost;
    logic [31:0] o_out_ref;
    logic [10:0] o_occupancy;

    four_ary_min_heap_queue_unit dut (.*);

    // shadow heap, 1-based
    logic [31:0] hp_cost [1:fahq_pkg::CAPACITY];
    logic [31:0] hp_ref  [1:fahq_pkg::CAPACITY];
    logic        hp_live [1:fahq_pkg::CAPACITY];
    int          hp_count = 0;

    t_op_item pending_ops[$];
    t_result  expected_results[$];
    int       error_count = 0;
    bit       stim_done = 1'b0;
    int       stall_hold = 0;
    longint   cycle_count = 0;

    always #4 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        error_count++;
    endtask

    function automatic int smallest_kid(input int node, input int tail);
        int first, n, a, b;
        first = 4 * node - 2;
        n = tail > first ? tail - first : 0;
        if (n > 4) n = 4;
        if (n < 2) return first;
        a = hp_cost[first] < hp_cost[first+1] ? first : first + 1;
        if (n == 2) return a;
        if (n == 3) return hp_cost[a] < hp_cost[first+2] ? a : first + 2;
        b = hp_cost[first+2] < hp_cost[first+3] ? first + 2 : first + 3;
        return hp_cost[a] < hp_cost[b] ? a : b;
    endfunction

    function automatic void sift_up(input int hole, input logic [31:0] c,
                                    input logic [31:0] r, input logic v);
        while (hole > 1 && c < hp_cost[(hole+2)/4]) begin
            hp_cost[hole] = hp_cost[(hole+2)/4];
            hp_ref[hole]  = hp_ref[(hole+2)/4];
            hp_live[hole] = hp_live[(hole+2)/4];
            hole = (hole + 2) / 4;
        end
        hp_cost[hole] = c;
        hp_ref[hole]  = r;
        hp_live[hole] = v;
    endfunction

    // compute the result of one operation and update the shadow heap
    function automatic t_result predict_heap_op(input t_op_item it);
        t_result res;
        int tail, hole, kid;
        logic [31:0] rc, rr;
        logic rv;
        res = '{fahq_pkg::ST_OK, 32'd0, 32'd0, 11'd0};
        if (it.op == fahq_pkg::OP_INSERT) begin
            if (hp_count >= fahq_pkg::CAPACITY) res.status = fahq_pkg::ST_FULL;
            else begin
                hp_count++;
                sift_up(hp_count, it.cost, it.refw, it.live);
            end
        end else begin
            forever begin
                if (hp_count == 0) begin
                    res.status = fahq_pkg::ST_EMPTY;
                    break;
                end
                rc = hp_cost[1]; rr = hp_ref[1]; rv = hp_live[1];
                tail = hp_count + 1;
                hole = 1;
                kid = smallest_kid(hole, tail);
                tail--;
                while (kid < tail) begin
                    kid = smallest_kid(hole, tail);
                    hp_cost[hole] = hp_cost[kid];
                    hp_ref[hole]  = hp_ref[kid];
                    hp_live[hole] = hp_live[kid];
                    hole = kid;
                    kid = 4 * hole - 2;
                end
                sift_up(hole, hp_cost[tail], hp_ref[tail], hp_live[tail]);
                hp_count = tail - 1;
                if (rv) begin
                    res.cost = rc;
                    res.refw = rr;
                    break;
                end
            end
        end
        res.occ = 11'(hp_count);
        return res;
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40)
                                             : $urandom_range(0, 2);
    endfunction

    function automatic logic [31:0] rand_cost();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_op(input logic op, input logic [31:0] c,
                          input logic [31:0] r, input logic v);
        t_op_item it;
        it = '{op, c, r, v};
        pending_ops.push_back(it);
    endtask

    // stimulus: directed corners, a fill to full, then random phases
    initial begin
        int n, bias;
        add_op(fahq_pkg::OP_POP, 32'd0, 32'd0, 1'b1);
        add_op(fahq_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        add_op(fahq_pkg::OP_INSERT, 32'd0, 32'h0, 1'b0);
        add_op(fahq_pkg::OP_INSERT, 32'd5, 32'hA5A5_5A5A, 1'b1);
        add_op(fahq_pkg::OP_INSERT, 32'd5, 32'h5A5A_A5A5, 1'b1);
        add_op(fahq_pkg::OP_INSERT, 32'd5, 32'h1234_5678, 1'b0);
        add_op(fahq_pkg::OP_INSERT, 32'd3, 32'h0, 1'b0);
        add_op(fahq_pkg::OP_POP, 32'd0, 32'd0, 1'b1);
        add_op(fahq_pkg::OP_POP, 32'd0, 32'd0, 1'b1);
        add_op(fahq_pkg::OP_INSERT, 32'd7, 32'h1, 1'b0);
        add_op(fahq_pkg::OP_POP, 32'd0, 32'd0, 1'b1);
        add_op(fahq_pkg::OP_POP, 32'd0, 32'd0, 1'b1);
        add_op(fahq_pkg::OP_INSERT, 32'd9, 32'h2, 1'b0);
        add_op(fahq_pkg::OP_POP, 32'd0, 32'd0, 1'b1);
        add_op(fahq_pkg::OP_POP, 32'd0, 32'd0, 1'b1);
        // fill past capacity to reach full inserts, then drain partly
        for (int k = 0; k < fahq_pkg::CAPACITY + 3; k++)
            add_op(fahq_pkg::OP_INSERT, rand_cost(), $urandom, $urandom_range(0, 7) != 0);
        for (int k = 0; k < 300; k++)
            add_op(fahq_pkg::OP_POP, $urandom, $urandom, $urandom_range(0, 1));
        // random phases with varying insert bias
        n = 0;
        while (n < 500) begin
            bias = $urandom_range(20, 80);
            for (int k = 0; k < 100; k++) begin
                add_op($urandom_range(0, 99) < bias ? fahq_pkg::OP_INSERT
                                                    : fahq_pkg::OP_POP,
                       rand_cost(), $urandom, $urandom_range(0, 4) != 0);
                n++;
            end
        end
        for (int k = 0; k < 150; k++)
            add_op(fahq_pkg::OP_POP, $urandom, $urandom, $urandom_range(0, 1));
        stim_done = 1'b1;
    end

    // reset and cycle limit
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("four_ary_min_heap_queue_unit_tb NOT OK");
            $finish;
        end
    end

    // driver: offers queued operations with random gaps
    int drv_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                expected_results.push_back(predict_heap_op('{i_opcode, i_key_cost,
                                                            i_entry_ref, i_entry_live}));
            if (!i_in_valid || o_in_ready) begin
                if (drv_gap > 0) begin
                    drv_gap <= drv_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_ops.size() > 0) begin
                    t_op_item it;
                    it = pending_ops.pop_front();
                    i_in_valid   <= 1'b1;
                    i_opcode     <= it.op;
                    i_key_cost   <= it.cost;
                    i_entry_ref  <= it.refw;
                    i_entry_live <= it.live;
                    drv_gap      <= gap_len();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output stall control, with one long hold-off early on
    int rdy_gap = 0;
    bit long_stall_done = 1'b0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!long_stall_done && cycle_count == 3000) begin
                stall_hold <= 2000;
                long_stall_done <= 1'b1;
                i_out_ready <= 1'b0;
            end else if (stall_hold > 0) begin
                stall_hold <= stall_hold - 1;
                i_out_ready <= 1'b0;
            end else if (rdy_gap > 0) begin
                rdy_gap <= rdy_gap - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) rdy_gap <= gap_len();
            end
        end
    end

    // monitor: compares each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transfer", 32'd1, 32'd0);
            end else begin
                t_result w;
                w = expected_results.pop_front();
                if (o_status !== w.status) report_mismatch("status", 32'(o_status), 32'(w.status));
                if (o_out_cost !== w.cost) report_mismatch("cost", o_out_cost, w.cost);
                if (o_out_ref !== w.refw) report_mismatch("ref", o_out_ref, w.refw);
                if (o_occupancy !== w.occ) report_mismatch("occupancy", 32'(o_occupancy), 32'(w.occ));
            end
        end
    end

    // end of run
    initial begin
        wait (stim_done);
        wait (pending_ops.size() == 0 && !i_in_valid);
        wait (expected_results.size() == 0);
        repeat (200) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("four_ary_min_heap_queue_unit_tb OK");
        else
            $display("four_ary_min_heap_queue_unit_tb NOT OK");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+design
design/fahq_pkg.sv
design/fahq_datapath.sv
design/fahq_ctrl.sv
design/four_ary_min_heap_queue_unit.sv
bench/four_ary_min_heap_queue_unit_tb.sv
